/* rtl/pbt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pbt_pkg
// Shared types and constants of the particle bounce tick engine.
// ----------------------------------------------------------------------------
package pbt_pkg;

    localparam int WORD_W = 32;

    // input operation codes
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_LAUNCH  = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;
    localparam logic [1:0] OP_UNUSED  = 2'd3;

    // central field modes
    localparam logic [1:0] FIELD_NONE    = 2'd0;
    localparam logic [1:0] FIELD_ATTRACT = 2'd1;
    localparam logic [1:0] FIELD_REPEL   = 2'd2;
    localparam logic [1:0] FIELD_UNUSED  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_GRAVITY_X      = 2'd0;
    localparam logic [1:0] REG_GRAVITY_Y      = 2'd1;
    localparam logic [1:0] REG_FIELD_MODE     = 2'd2;
    localparam logic [1:0] REG_FIELD_STRENGTH = 2'd3;

    localparam logic [31:0] TICKS_PER_SEC = 32'd1000;
    localparam logic [23:0] RELEASE_TICKS = 24'd100;
    localparam logic [4:0]  BURST_TICKS   = 5'd20;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_GX,
        ST_GY,
        ST_SQX,
        ST_SQY,
        ST_DIST,
        ST_ACCEL,
        ST_AXM,
        ST_AXD,
        ST_AYM,
        ST_AYD,
        ST_PX,
        ST_RX,
        ST_PY,
        ST_RY,
        ST_FX,
        ST_FY,
        ST_FS,
        ST_FM,
        ST_AGE,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

/* rtl/pbt_mul.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pbt_mul
// Bit-serial unsigned 32x32 multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module pbt_mul (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           start,
    input  wire logic [pbt_pkg::WORD_W-1:0]     op_a,
    input  wire logic [pbt_pkg::WORD_W-1:0]     op_b,
    output logic                                done,
    output logic [2*pbt_pkg::WORD_W-1:0]        prod
);

    localparam int W = pbt_pkg::WORD_W;

    logic               busy_reg;
    logic               done_reg;
    logic [$clog2(W)-1:0] cnt_reg;
    logic [W-1:0]       a_reg;
    logic [2*W-1:0]     p_reg;
    logic [W:0]         hi_sum;

    // add multiplicand into the upper half when the low bit is set
    assign hi_sum = {1'b0, p_reg[2*W-1:W]} + (p_reg[0] ? {1'b0, a_reg} : '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == '1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg <= op_a;
            p_reg <= {{W{1'b0}}, op_b};
        end else if (busy_reg) begin
            p_reg <= {hi_sum, p_reg[W-1:1]};
        end
    end

    assign done = done_reg;
    assign prod = p_reg;

endmodule
`default_nettype wire

/* rtl/pbt_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pbt_div
// Restoring radix-2 divider, 64-bit dividend by 32-bit divisor.
// A short operation takes a 32-bit dividend and runs half the steps.
// ----------------------------------------------------------------------------
module pbt_div (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           start,
    input  wire logic                           short_op,
    input  wire logic [2*pbt_pkg::WORD_W-1:0]   dividend,
    input  wire logic [pbt_pkg::WORD_W-1:0]     divisor,
    output logic                                done,
    output logic [2*pbt_pkg::WORD_W-1:0]        quot
);

    localparam int W  = pbt_pkg::WORD_W;
    localparam int CW = $clog2(2*W);

    logic                   busy_reg;
    logic                   done_reg;
    logic [CW-1:0]          cnt_reg;
    logic [W-1:0]           d_reg;
    logic [W-1:0]           rem_reg;
    logic [2*W-1:0]         q_reg;
    logic [W:0]             rem_sh;
    logic [W:0]             rem_sub;
    logic                   fits;

    assign rem_sh  = {rem_reg, q_reg[2*W-1]};
    assign rem_sub = rem_sh - {1'b0, d_reg};
    assign fits    = rem_sh >= {1'b0, d_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                // skip the upper half of a short dividend
                cnt_reg  <= short_op ? CW'(W) : '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == '1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            d_reg   <= divisor;
            rem_reg <= '0;
            q_reg   <= short_op ? {dividend[W-1:0], {W{1'b0}}} : dividend;
        end else if (busy_reg) begin
            rem_reg <= fits ? rem_sub[W-1:0] : rem_sh[W-1:0];
            q_reg   <= {q_reg[2*W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule
`default_nettype wire

/* rtl/pbt_sqrt.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pbt_sqrt
// Digit-by-digit integer square root of a 64-bit value, two radicand bits
// and one root bit per cycle.
// ----------------------------------------------------------------------------
module pbt_sqrt (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           start,
    input  wire logic [2*pbt_pkg::WORD_W-1:0]   radicand,
    output logic                                done,
    output logic [pbt_pkg::WORD_W-1:0]          root
);

    localparam int W = pbt_pkg::WORD_W;

    logic                 busy_reg;
    logic                 done_reg;
    logic [$clog2(W)-1:0] cnt_reg;
    logic [2*W-1:0]       rad_reg;
    logic [W+1:0]         rem_reg;
    logic [W-1:0]         root_reg;
    logic [W+3:0]         rem_sh;
    logic [W+3:0]         trial;
    logic [W+3:0]         rem_sub;
    logic                 fits;

    assign rem_sh  = {rem_reg, rad_reg[2*W-1:2*W-2]};
    assign trial   = {2'b00, root_reg, 2'b01};
    assign rem_sub = rem_sh - trial;
    assign fits    = rem_sh >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == '1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[2*W-3:0], 2'b00};
            rem_reg  <= fits ? rem_sub[W+1:0] : rem_sh[W+1:0];
            root_reg <= {root_reg[W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule
`default_nettype wire

/* rtl/particle_bounce_physics_tick.sv */
`default_nettype none
// Launch, release, unused codes and dead-particle ticks pass straight to ST_DONE.
// A live tick runs gravity and motion, plus the central field when it is on and the
// impact force after a wall hit: every multiply, divide and root runs bit-serially
// on a serial unit, and the two field divides take a full 64-bit dividend.
// One word at a time; the next word is taken once the last one is done.
// Reset (synchronous, aresetn low): no particle, state zero; acc/dist/accel/output data not reset.
// ----------------------------------------------------------------------------
// particle_bounce_physics_tick
// One-particle box physics engine: gravity, central field, wall bounce,
// impact force and aging, sequenced over shared serial arithmetic units.
// ----------------------------------------------------------------------------
module particle_bounce_physics_tick #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // configuration
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    // input words
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_operation,
    input  wire logic [17:0]        s_start_x,
    input  wire logic [17:0]        s_start_y,
    input  wire logic [31:0]        s_start_vx,
    input  wire logic [31:0]        s_start_vy,
    input  wire logic [23:0]        s_mass,
    input  wire logic [16:0]        s_elasticity,
    input  wire logic [23:0]        s_lifetime_ticks,
    // result words
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_collided,
    output logic [31:0]             m_impact_force,
    output logic [5:0]              m_mode_count,
    output logic                    m_alive,
    output logic                    m_burst_active,
    output logic [17:0]             m_pos_x,
    output logic [17:0]             m_pos_y
);

    localparam logic signed [33:0] ONE_P     = 34'sd1 <<< FRAC_BITS;
    localparam logic signed [33:0] NEG_ONE_P = -ONE_P;
    localparam logic [31:0]        FIELD_MIN = 32'((64'd1 << FRAC_BITS) / 100);

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------
    function automatic logic [31:0] sat32(input logic signed [65:0] v);
        logic [31:0] r;
        if (v > 66'sh0_7FFF_FFFF)
            r = 32'h7FFF_FFFF;
        else if (v < -66'sh0_8000_0000)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    function automatic logic [31:0] add_sat(input logic [31:0] v, input logic [63:0] q,
                                            input logic neg);
        logic signed [65:0] sv;
        logic signed [65:0] sq;
        sv = $signed({{34{v[31]}}, v});
        sq = $signed({2'b00, q});
        return sat32(neg ? sv - sq : sv + sq);
    endfunction

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [31:0] gx_reg, gy_reg;
    logic [1:0]  fmode_reg;
    logic [30:0] fstr_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gx_reg    <= '0;
            gy_reg    <= '0;
            fmode_reg <= '0;
            fstr_reg  <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                pbt_pkg::REG_GRAVITY_X:      gx_reg    <= pwdata;
                pbt_pkg::REG_GRAVITY_Y:      gy_reg    <= pwdata;
                pbt_pkg::REG_FIELD_MODE:     fmode_reg <= pwdata[1:0];
                pbt_pkg::REG_FIELD_STRENGTH: fstr_reg  <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            pbt_pkg::REG_GRAVITY_X:      prdata = gx_reg;
            pbt_pkg::REG_GRAVITY_Y:      prdata = gy_reg;
            pbt_pkg::REG_FIELD_MODE:     prdata = {30'd0, fmode_reg};
            pbt_pkg::REG_FIELD_STRENGTH: prdata = {1'b0, fstr_reg};
            default:                     prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // serial units
    // ------------------------------------------------------------------
    logic        mul_start, div_start, sqrt_start;
    logic        mul_done, div_done, sqrt_done;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_prod;
    logic        div_short;
    logic [63:0] div_dividend;
    logic [31:0] div_divisor;
    logic [63:0] div_quot;
    logic [63:0] sqrt_rad;
    logic [31:0] sqrt_root;

    pbt_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    pbt_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .short_op (div_short),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quot     (div_quot)
    );

    pbt_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (sqrt_rad),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    pbt_pkg::state_t state_reg, state_next;
    logic        busy_reg, busy_next;
    logic        m_valid_reg, m_valid_next;
    logic [31:0] px_reg, px_next, py_reg, py_next;
    logic [31:0] vx_reg, vx_next, vy_reg, vy_next;
    logic [23:0] mass_reg, mass_next;
    logic [16:0] elas_reg, elas_next;
    logic [23:0] limit_reg, limit_next;
    logic [23:0] age_reg, age_next;
    logic        alive_reg, alive_next;
    logic [4:0]  tsh_reg, tsh_next;
    logic [31:0] force_reg, force_next;
    logic        live_reg, live_next;
    logic        hit_reg, hit_next;
    logic [63:0] acc_reg, acc_next;
    logic [31:0] dist_reg, dist_next;
    logic [31:0] accel_reg, accel_next;
    logic        out_load;

    logic        o_collided_reg;
    logic [31:0] o_force_reg;
    logic [5:0]  o_mode_reg;
    logic        o_alive_reg, o_burst_reg;
    logic [17:0] o_px_reg, o_py_reg;

    logic signed [33:0] pos_new;
    logic [47:0]        refl_mag;
    logic [47:0]        force_raw;
    logic [23:0]        age_inc;
    logic [36:0]        force_x20;
    logic [36:0]        modes_raw;
    logic [5:0]         mode_val;
    logic               repel;

    assign s_ready   = (state_reg == pbt_pkg::ST_IDLE);
    assign repel     = (fmode_reg == pbt_pkg::FIELD_REPEL);
    assign refl_mag  = mul_prod[63:16];
    assign force_raw = mul_prod[63:16];
    assign age_inc   = (age_reg == 24'hFF_FFFF) ? age_reg : age_reg + 24'd1;

    assign force_x20 = {1'b0, force_reg, 4'b0} + {3'b0, force_reg, 2'b0};
    assign modes_raw = force_x20 >> FRAC_BITS;
    assign mode_val  = (modes_raw > 37'd28) ? 6'd32 : modes_raw[5:0] + 6'd4;

    // position step for the axis in work
    always_comb begin
        logic [31:0] p;
        logic [31:0] v;
        logic signed [33:0] sp;
        logic signed [33:0] sq;
        p  = (state_reg == pbt_pkg::ST_PY) ? py_reg : px_reg;
        v  = (state_reg == pbt_pkg::ST_PY) ? vy_reg : vx_reg;
        sp = $signed({{2{p[31]}}, p});
        sq = $signed({2'b00, div_quot[31:0]});
        pos_new = v[31] ? sp - sq : sp + sq;
    end

    // operand selection for the shared units
    always_comb begin
        mul_a        = '0;
        mul_b        = '0;
        div_short    = 1'b1;
        div_dividend = '0;
        div_divisor  = pbt_pkg::TICKS_PER_SEC;
        sqrt_rad     = acc_reg;
        case (state_reg)
            pbt_pkg::ST_GX:    div_dividend = {32'd0, mag32(gx_reg)};
            pbt_pkg::ST_GY:    div_dividend = {32'd0, mag32(gy_reg)};
            pbt_pkg::ST_ACCEL: div_dividend = {32'd0, fstr_reg, 1'b0};
            pbt_pkg::ST_AXD, pbt_pkg::ST_AYD: begin
                div_short    = 1'b0;
                div_dividend = acc_reg;
                div_divisor  = dist_reg;
            end
            pbt_pkg::ST_PX:    div_dividend = {32'd0, mag32(vx_reg)};
            pbt_pkg::ST_PY:    div_dividend = {32'd0, mag32(vy_reg)};
            pbt_pkg::ST_SQX: begin
                mul_a = mag32(px_reg);
                mul_b = mag32(px_reg);
            end
            pbt_pkg::ST_SQY: begin
                mul_a = mag32(py_reg);
                mul_b = mag32(py_reg);
            end
            pbt_pkg::ST_AXM: begin
                mul_a = mag32(px_reg);
                mul_b = accel_reg;
            end
            pbt_pkg::ST_AYM: begin
                mul_a = mag32(py_reg);
                mul_b = accel_reg;
            end
            pbt_pkg::ST_RX: begin
                mul_a = mag32(vx_reg);
                mul_b = {15'd0, elas_reg};
            end
            pbt_pkg::ST_RY: begin
                mul_a = mag32(vy_reg);
                mul_b = {15'd0, elas_reg};
            end
            pbt_pkg::ST_FX: begin
                mul_a = mag32(vx_reg);
                mul_b = mag32(vx_reg);
            end
            pbt_pkg::ST_FY: begin
                mul_a = mag32(vy_reg);
                mul_b = mag32(vy_reg);
            end
            pbt_pkg::ST_FM: begin
                mul_a = dist_reg;
                mul_b = {8'd0, mass_reg};
            end
            default: ;
        endcase
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        vx_next      = vx_reg;
        vy_next      = vy_reg;
        mass_next    = mass_reg;
        elas_next    = elas_reg;
        limit_next   = limit_reg;
        age_next     = age_reg;
        alive_next   = alive_reg;
        tsh_next     = tsh_reg;
        force_next   = force_reg;
        live_next    = live_reg;
        hit_next     = hit_reg;
        acc_next     = acc_reg;
        dist_next    = dist_reg;
        accel_next   = accel_reg;
        mul_start    = 1'b0;
        div_start    = 1'b0;
        sqrt_start   = 1'b0;
        out_load     = 1'b0;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready)
            m_valid_next = 1'b0;

        unique case (state_reg)
            pbt_pkg::ST_IDLE: begin
                if (s_valid) begin
                    hit_next   = 1'b0;
                    live_next  = alive_reg;
                    state_next = pbt_pkg::ST_DONE;
                    case (s_operation)
                        pbt_pkg::OP_TICK: begin
                            if (alive_reg)
                                state_next = pbt_pkg::ST_GX;
                        end
                        pbt_pkg::OP_LAUNCH: begin
                            px_next    = {{14{s_start_x[17]}}, s_start_x};
                            py_next    = {{14{s_start_y[17]}}, s_start_y};
                            vx_next    = s_start_vx;
                            vy_next    = s_start_vy;
                            mass_next  = s_mass;
                            elas_next  = s_elasticity;
                            limit_next = s_lifetime_ticks;
                            age_next   = '0;
                            tsh_next   = '0;
                            alive_next = 1'b1;
                            live_next  = 1'b1;
                        end
                        pbt_pkg::OP_RELEASE: limit_next = pbt_pkg::RELEASE_TICKS;
                        default: ;
                    endcase
                end
            end
            pbt_pkg::ST_GX: begin
                div_start = !busy_reg;
                if (div_done) begin
                    vx_next    = add_sat(vx_reg, div_quot, gx_reg[31]);
                    state_next = pbt_pkg::ST_GY;
                end
            end
            pbt_pkg::ST_GY: begin
                div_start = !busy_reg;
                if (div_done) begin
                    vy_next = add_sat(vy_reg, div_quot, gy_reg[31]);
                    if (fmode_reg == pbt_pkg::FIELD_ATTRACT || repel)
                        state_next = pbt_pkg::ST_SQX;
                    else
                        state_next = pbt_pkg::ST_PX;
                end
            end
            pbt_pkg::ST_SQX: begin
                mul_start = !busy_reg;
                if (mul_done) begin
                    acc_next   = mul_prod;
                    state_next = pbt_pkg::ST_SQY;
                end
            end
            pbt_pkg::ST_SQY: begin
                mul_start = !busy_reg;
                if (mul_done) begin
                    acc_next   = acc_reg + mul_prod;
                    state_next = pbt_pkg::ST_DIST;
                end
            end
            pbt_pkg::ST_DIST: begin
                sqrt_start = !busy_reg;
                if (sqrt_done) begin
                    dist_next  = sqrt_root;
                    // field only acts away from the center
                    state_next = (sqrt_root > FIELD_MIN) ? pbt_pkg::ST_ACCEL
                                                         : pbt_pkg::ST_PX;
                end
            end
            pbt_pkg::ST_ACCEL: begin
                div_start = !busy_reg;
                if (div_done) begin
                    accel_next = div_quot[31:0];
                    state_next = pbt_pkg::ST_AXM;
                end
            end
            pbt_pkg::ST_AXM: begin
                mul_start = !busy_reg;
                if (mul_done) begin
                    acc_next   = mul_prod;
                    state_next = pbt_pkg::ST_AXD;
                end
            end
            pbt_pkg::ST_AXD: begin
                div_start = !busy_reg;
                if (div_done) begin
                    // pull toward the origin (push away when repelling): sign opposite to the position
                    vx_next    = add_sat(vx_reg, div_quot, ~px_reg[31] ^ repel);
                    state_next = pbt_pkg::ST_AYM;
                end
            end
            pbt_pkg::ST_AYM: begin
                mul_start = !busy_reg;
                if (mul_done) begin
                    acc_next   = mul_prod;
                    state_next = pbt_pkg::ST_AYD;
                end
            end
            pbt_pkg::ST_AYD: begin
                div_start = !busy_reg;
                if (div_done) begin
                    vy_next    = add_sat(vy_reg, div_quot, ~py_reg[31] ^ repel);
                    state_next = pbt_pkg::ST_PX;
                end
            end
            pbt_pkg::ST_PX: begin
                div_start = !busy_reg;
                if (div_done) begin
                    state_next = pbt_pkg::ST_PY;
                    if (pos_new > ONE_P) begin
                        px_next    = ONE_P[31:0];
                        hit_next   = 1'b1;
                        state_next = pbt_pkg::ST_RX;
                    end else if (pos_new < NEG_ONE_P) begin
                        px_next    = NEG_ONE_P[31:0];
                        hit_next   = 1'b1;
                        state_next = pbt_pkg::ST_RX;
                    end else begin
                        px_next = pos_new[31:0];
                    end
                end
            end
            pbt_pkg::ST_RX: begin
                mul_start = !busy_reg;
                if (mul_done) begin
                    vx_next    = add_sat(32'd0, {16'd0, refl_mag}, ~vx_reg[31]);
                    state_next = pbt_pkg::ST_PY;
                end
            end
            pbt_pkg::ST_PY: begin
                div_start = !busy_reg;
                if (div_done) begin
                    state_next = hit_reg ? pbt_pkg::ST_FX : pbt_pkg::ST_AGE;
                    if (pos_new > ONE_P) begin
                        py_next    = ONE_P[31:0];
                        hit_next   = 1'b1;
                        state_next = pbt_pkg::ST_RY;
                    end else if (pos_new < NEG_ONE_P) begin
                        py_next    = NEG_ONE_P[31:0];
                        hit_next   = 1'b1;
                        state_next = pbt_pkg::ST_RY;
                    end else begin
                        py_next = pos_new[31:0];
                    end
                end
            end
            pbt_pkg::ST_RY: begin
                mul_start = !busy_reg;
                if (mul_done) begin
                    vy_next    = add_sat(32'd0, {16'd0, refl_mag}, ~vy_reg[31]);
                    state_next = pbt_pkg::ST_FX;
                end
            end
            pbt_pkg::ST_FX: begin
                mul_start = !busy_reg;
                if (mul_done) begin
                    acc_next   = mul_prod;
                    state_next = pbt_pkg::ST_FY;
                end
            end
            pbt_pkg::ST_FY: begin
                mul_start = !busy_reg;
                if (mul_done) begin
                    acc_next   = acc_reg + mul_prod;
                    state_next = pbt_pkg::ST_FS;
                end
            end
            pbt_pkg::ST_FS: begin
                sqrt_start = !busy_reg;
                if (sqrt_done) begin
                    dist_next  = sqrt_root;
                    state_next = pbt_pkg::ST_FM;
                end
            end
            pbt_pkg::ST_FM: begin
                mul_start = !busy_reg;
                if (mul_done) begin
                    force_next = (|force_raw[47:32]) ? 32'hFFFF_FFFF : force_raw[31:0];
                    state_next = pbt_pkg::ST_AGE;
                end
            end
            pbt_pkg::ST_AGE: begin
                age_next = age_inc;
                if (age_inc >= limit_reg)
                    alive_next = 1'b0;
                // a hit restarts the count, which then advances once
                if (hit_reg)
                    tsh_next = 5'd1;
                else if (tsh_reg != 5'd31)
                    tsh_next = tsh_reg + 5'd1;
                state_next = pbt_pkg::ST_DONE;
            end
            pbt_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = pbt_pkg::ST_IDLE;
                end
            end
            default: state_next = pbt_pkg::ST_IDLE;
        endcase

        busy_next = busy_reg;
        if (mul_start || div_start || sqrt_start)
            busy_next = 1'b1;
        if (mul_done || div_done || sqrt_done)
            busy_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pbt_pkg::ST_IDLE;
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            px_reg      <= '0;
            py_reg      <= '0;
            vx_reg      <= '0;
            vy_reg      <= '0;
            mass_reg    <= '0;
            elas_reg    <= '0;
            limit_reg   <= '0;
            age_reg     <= '0;
            alive_reg   <= 1'b0;
            tsh_reg     <= '0;
            force_reg   <= '0;
            live_reg    <= 1'b0;
            hit_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
            px_reg      <= px_next;
            py_reg      <= py_next;
            vx_reg      <= vx_next;
            vy_reg      <= vy_next;
            mass_reg    <= mass_next;
            elas_reg    <= elas_next;
            limit_reg   <= limit_next;
            age_reg     <= age_next;
            alive_reg   <= alive_next;
            tsh_reg     <= tsh_next;
            force_reg   <= force_next;
            live_reg    <= live_next;
            hit_reg     <= hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg   <= acc_next;
        dist_reg  <= dist_next;
        accel_reg <= accel_next;
        if (out_load) begin
            o_collided_reg <= hit_reg;
            o_force_reg    <= force_reg;
            o_mode_reg     <= mode_val;
            o_alive_reg    <= alive_reg;
            o_burst_reg    <= live_reg && (tsh_reg < pbt_pkg::BURST_TICKS);
            o_px_reg       <= px_reg[17:0];
            o_py_reg       <= py_reg[17:0];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_collided     = o_collided_reg;
    assign m_impact_force = o_force_reg;
    assign m_mode_count   = o_mode_reg;
    assign m_alive        = o_alive_reg;
    assign m_burst_active = o_burst_reg;
    assign m_pos_x        = o_px_reg;
    assign m_pos_y        = o_py_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_one_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({mul_start, div_start, sqrt_start}))
        else $error("two serial units started together");

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !(mul_start || div_start || sqrt_start))
        else $error("serial unit started while one is running");

    a_take_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while a word is in work");

    a_mode_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_mode_count >= 6'd4 && m_mode_count <= 6'd32))
        else $error("mode count out of range");

endmodule
`default_nettype wire
